>>> design/go_back_n_sender_core_assert.svh
// Assertion macros shared by the go-back-N sender modules.
`ifndef GO_BACK_N_SENDER_CORE_ASSERT_SVH
`define GO_BACK_N_SENDER_CORE_ASSERT_SVH

`ifndef SYNTH
// Check a property at every rising clock edge, disabled while reset is held.
`define GBN_ASSERT(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("go_back_n_sender_core: assertion failed");
// Check a property at every rising clock edge, reset included.
`define GBN_ASSERT_ALWAYS(name, clk, prop) \
  name: assert property (@(posedge clk) prop) \
    else $error("go_back_n_sender_core: assertion failed");
`else
`define GBN_ASSERT(name, clk, rst_n, prop)
`define GBN_ASSERT_ALWAYS(name, clk, prop)
`endif

`endif

>>> design/gbn_pkg.sv
// Types and constants shared by the go-back-N sender modules.
`timescale 1ns / 1ps

package gbn_pkg;

  localparam int unsigned SeqW  = 16;
  localparam int unsigned RetxW = 32;
  localparam int unsigned OutsW = 6;
  localparam int unsigned WinW  = 6;
  localparam int unsigned CfgW  = 16;
  localparam int unsigned CfgIdxW = 2;

  // Input item function codes
  localparam logic [1:0] FUNC_TICK  = 2'd0;
  localparam logic [1:0] FUNC_ACK   = 2'd1;
  localparam logic [1:0] FUNC_ABORT = 2'd2;
  localparam logic [1:0] FUNC_START = 2'd3;

  // Result kinds
  localparam logic [1:0] KIND_SEND     = 2'd0;
  localparam logic [1:0] KIND_RUNNING  = 2'd1;
  localparam logic [1:0] KIND_FINISHED = 2'd2;
  localparam logic [1:0] KIND_IDLE     = 2'd3;

  // Configuration register indexes and reset values
  localparam logic [CfgIdxW-1:0] REG_WINDOW_SIZE   = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_MESSAGE_COUNT = 2'd1;
  localparam logic [CfgIdxW-1:0] REG_TIMEOUT_TICKS = 2'd2;

  localparam logic [WinW-1:0] WINDOW_SIZE_RST   = 6'd4;
  localparam logic [SeqW-1:0] MESSAGE_COUNT_RST = 16'd1000;
  localparam logic [SeqW-1:0] TIMEOUT_TICKS_RST = 16'd1500;

  typedef enum logic [1:0] {
    RS_IDLE     = 2'd0,
    RS_RUNNING  = 2'd1,
    RS_FINISHED = 2'd2,
    RS_ABORTED  = 2'd3
  } gbn_run_e;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic capture;  // latch the accepted input beat
    logic exec;     // apply the latched item to the run state
    logic send;     // load a send order into the output register
    logic status;   // load the closing status into the output register
  } gbn_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic can_send;
  } gbn_sts_t;

endpackage

>>> design/gbn_ctrl.sv
// Sequencer for the go-back-N sender: item handshake, send burst and output beat valid.
`timescale 1ns / 1ps
`include "go_back_n_sender_core_assert.svh"

module gbn_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output gbn_pkg::gbn_cmd_t cmd_o,
  input  gbn_pkg::gbn_sts_t sts_i
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_EXEC = 3'b010,
    ST_FILL = 3'b100
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;
  logic   accept;

  assign out_free = !out_valid_q || out_ready_i;
  assign accept   = in_valid_i && (state_q == ST_IDLE);

  always_comb begin
    state_d       = state_q;
    cmd_o         = '0;
    cmd_o.capture = accept;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) state_d = ST_EXEC;
      end
      ST_EXEC: begin
        cmd_o.exec = 1'b1;
        state_d    = ST_FILL;
      end
      ST_FILL: begin
        // issue send orders while allowed, then close with the status beat
        if (out_free) begin
          if (sts_i.can_send) begin
            cmd_o.send = 1'b1;
          end else begin
            cmd_o.status = 1'b1;
            state_d      = ST_IDLE;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.send || cmd_o.status) out_valid_d = 1'b1;
    else if (out_ready_i)           out_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;

  `GBN_ASSERT(a_accept_to_exec, clk_i, rst_ni, accept |=> state_q == ST_EXEC)
  `GBN_ASSERT(a_load_only_when_free, clk_i, rst_ni,
    (cmd_o.send || cmd_o.status) |-> out_free)
  `GBN_ASSERT(a_status_ends_item, clk_i, rst_ni,
    cmd_o.status |=> (state_q == ST_IDLE) && out_valid_q)

endmodule

>>> design/gbn_dp.sv
// Datapath of the go-back-N sender: configuration, window state and output register.
`timescale 1ns / 1ps
`include "go_back_n_sender_core_assert.svh"

module gbn_dp #(
  parameter int unsigned WINDOW_MAX = 32
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [gbn_pkg::CfgIdxW-1:0]       cfg_idx_i,
  input  logic [gbn_pkg::CfgW-1:0]          cfg_data_i,
  input  logic [1:0]                        in_func_i,
  input  logic [gbn_pkg::SeqW-1:0]          in_ack_seq_i,
  input  gbn_pkg::gbn_cmd_t                 cmd_i,
  output gbn_pkg::gbn_sts_t                 sts_o,
  output logic [1:0]                        out_kind_o,
  output logic [gbn_pkg::SeqW-1:0]          out_seq_o,
  output logic [gbn_pkg::RetxW-1:0]         out_retx_o,
  output logic [gbn_pkg::OutsW-1:0]         out_outstanding_o,
  output logic                              out_last_o
);

  localparam logic [6:0] WinMax = 7'(WINDOW_MAX);

  // configuration
  logic [gbn_pkg::WinW-1:0] win_q;
  logic [gbn_pkg::SeqW-1:0] msg_cnt_q;
  logic [gbn_pkg::SeqW-1:0] timeout_q;

  // latched item
  logic [1:0]               func_q;
  logic [gbn_pkg::SeqW-1:0] ack_q;

  // run state
  logic [gbn_pkg::SeqW-1:0]  base_q, base_d;
  logic [gbn_pkg::SeqW-1:0]  next_q, next_d;
  logic [gbn_pkg::SeqW-1:0]  timer_q, timer_d;
  logic [gbn_pkg::RetxW-1:0] resend_q, resend_d;
  gbn_pkg::gbn_run_e         run_q, run_d;
  logic                      fill_en_q, fill_en_d;

  // output register
  logic [1:0]                 kind_q, kind_d;
  logic [gbn_pkg::SeqW-1:0]   oseq_q, oseq_d;
  logic [gbn_pkg::RetxW-1:0]  oretx_q, oretx_d;
  logic [gbn_pkg::OutsW-1:0]  oouts_q, oouts_d;
  logic                       olast_q, olast_d;

  logic [gbn_pkg::SeqW-1:0]  pending;
  logic [6:0]                eff_win;
  logic                      window_full;
  logic [gbn_pkg::RetxW:0]   resend_sum;
  logic                      finish;
  gbn_pkg::gbn_run_e         run_final;

  assign pending = next_q - base_q;

  always_comb begin
    eff_win = {1'b0, win_q};
    if (win_q == '0)       eff_win = 7'd1;
    if (eff_win > WinMax)  eff_win = WinMax;
  end

  assign window_full    = pending >= {9'd0, eff_win};
  assign sts_o.can_send = fill_en_q && !window_full && (next_q < msg_cnt_q);
  assign resend_sum     = {1'b0, resend_q} + {17'd0, pending};
  assign finish         = (run_q == gbn_pkg::RS_RUNNING) && (next_q >= msg_cnt_q) &&
                          (pending == '0);
  assign run_final      = finish ? gbn_pkg::RS_FINISHED : run_q;

  always_comb begin
    base_d    = base_q;
    next_d    = next_q;
    timer_d   = timer_q;
    resend_d  = resend_q;
    run_d     = run_q;
    fill_en_d = fill_en_q;
    kind_d    = kind_q;
    oseq_d    = oseq_q;
    oretx_d   = oretx_q;
    oouts_d   = oouts_q;
    olast_d   = olast_q;

    if (cmd_i.exec) begin
      fill_en_d = 1'b0;
      if (func_q == gbn_pkg::FUNC_START) begin
        base_d    = '0;
        next_d    = '0;
        timer_d   = '0;
        resend_d  = '0;
        run_d     = gbn_pkg::RS_RUNNING;
        fill_en_d = 1'b1;
      end else if (run_q == gbn_pkg::RS_RUNNING) begin
        unique case (func_q)
          gbn_pkg::FUNC_ABORT: run_d = gbn_pkg::RS_ABORTED;
          gbn_pkg::FUNC_ACK: begin
            // only the oldest outstanding number slides the window
            if (ack_q == base_q && pending != '0) begin
              base_d    = base_q + 16'd1;
              timer_d   = '0;
              fill_en_d = 1'b1;
            end
          end
          gbn_pkg::FUNC_TICK: begin
            if (window_full) begin
              if (timer_q >= timeout_q) begin
                // go back to base and count every outstanding packet as resent
                resend_d  = resend_sum[gbn_pkg::RetxW] ? '1 : resend_sum[gbn_pkg::RetxW-1:0];
                next_d    = base_q;
                timer_d   = '0;
                fill_en_d = 1'b1;
              end else begin
                timer_d = timer_q + 16'd1;
              end
            end else begin
              timer_d = '0;
            end
          end
          default: ;
        endcase
      end
    end

    if (cmd_i.send) begin
      next_d  = next_q + 16'd1;
      kind_d  = gbn_pkg::KIND_SEND;
      oseq_d  = next_q;
      oretx_d = resend_q;
      oouts_d = gbn_pkg::OutsW'(pending + 16'd1);
      olast_d = 1'b0;
    end

    if (cmd_i.status) begin
      run_d   = run_final;
      oseq_d  = base_q;
      oretx_d = resend_q;
      oouts_d = pending[gbn_pkg::OutsW-1:0];
      olast_d = 1'b1;
      unique case (run_final)
        gbn_pkg::RS_RUNNING:  kind_d = gbn_pkg::KIND_RUNNING;
        gbn_pkg::RS_FINISHED: kind_d = gbn_pkg::KIND_FINISHED;
        default:              kind_d = gbn_pkg::KIND_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q     <= gbn_pkg::WINDOW_SIZE_RST;
      msg_cnt_q <= gbn_pkg::MESSAGE_COUNT_RST;
      timeout_q <= gbn_pkg::TIMEOUT_TICKS_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        gbn_pkg::REG_WINDOW_SIZE:   win_q     <= cfg_data_i[gbn_pkg::WinW-1:0];
        gbn_pkg::REG_MESSAGE_COUNT: msg_cnt_q <= cfg_data_i;
        gbn_pkg::REG_TIMEOUT_TICKS: timeout_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q    <= '0;
      next_q    <= '0;
      timer_q   <= '0;
      resend_q  <= '0;
      run_q     <= gbn_pkg::RS_IDLE;
      fill_en_q <= 1'b0;
    end else begin
      base_q    <= base_d;
      next_q    <= next_d;
      timer_q   <= timer_d;
      resend_q  <= resend_d;
      run_q     <= run_d;
      fill_en_q <= fill_en_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      func_q <= in_func_i;
      ack_q  <= in_ack_seq_i;
    end
    kind_q  <= kind_d;
    oseq_q  <= oseq_d;
    oretx_q <= oretx_d;
    oouts_q <= oouts_d;
    olast_q <= olast_d;
  end

  assign out_kind_o        = kind_q;
  assign out_seq_o         = oseq_q;
  assign out_retx_o        = oretx_q;
  assign out_outstanding_o = oouts_q;
  assign out_last_o        = olast_q;

  `GBN_ASSERT_ALWAYS(a_pending_bounded, clk_i, pending <= {9'd0, WinMax})
  `GBN_ASSERT(a_resend_only_on_exec, clk_i, rst_ni, !cmd_i.exec |=> $stable(resend_q))
  `GBN_ASSERT(a_status_beat_is_last, clk_i, rst_ni,
    cmd_i.status |=> olast_q && (kind_q != gbn_pkg::KIND_SEND))

endmodule

>>> design/go_back_n_sender_core.sv
// Top level of the go-back-N sender: stream ports, controller and datapath.
`timescale 1ns / 1ps

// Go-back-N ARQ sender. Each input beat is a tick, an acknowledgement, an abort
// or a start; each produces zero or more send orders (kind 0) followed by one
// status beat with tlast high. An item is accepted, applied to the run state,
// then issues its send orders through the single output register and closes with
// the status beat; a stalled output stretches this. A resend burst restarts at
// the base and issues every outstanding number again, at most WINDOW_MAX orders.
// Write the configuration registers only while no item is in flight.
module go_back_n_sender_core #(
  parameter int unsigned WINDOW_MAX = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration: 0 window_size, 1 message_count, 2 timeout_ticks
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [15:0] cfg_data_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // ack_seq[15:0]
  input  logic [1:0]  s_axis_tuser,   // func[1:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [55:0] m_axis_tdata,   // seq[15:0], retransmit_count[47:16],
                                      // outstanding[53:48], zero pad
  output logic [1:0]  m_axis_tuser,   // kind[1:0]
  output logic        m_axis_tlast
);

  gbn_pkg::gbn_cmd_t cmd;
  gbn_pkg::gbn_sts_t sts;

  logic [1:0]  out_kind;
  logic [15:0] out_seq;
  logic [31:0] out_retx;
  logic [5:0]  out_outstanding;

  gbn_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  gbn_dp #(
    .WINDOW_MAX (WINDOW_MAX)
  ) u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_idx_i         (cfg_idx_i),
    .cfg_data_i        (cfg_data_i),
    .in_func_i         (s_axis_tuser),
    .in_ack_seq_i      (s_axis_tdata),
    .cmd_i             (cmd),
    .sts_o             (sts),
    .out_kind_o        (out_kind),
    .out_seq_o         (out_seq),
    .out_retx_o        (out_retx),
    .out_outstanding_o (out_outstanding),
    .out_last_o        (m_axis_tlast)
  );

  assign m_axis_tdata = {2'b00, out_outstanding, out_retx, out_seq};
  assign m_axis_tuser = out_kind;

endmodule
